FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the attitude error RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define QAE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition at one edge implies a consequence at the next edge.
`define QAE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/qae_pkg.sv
// Package for the quaternion attitude error core: widths, limits, side-band types,
// arctangent table and truncating shift. No dependencies.
`default_nettype none

package qae_pkg;

    localparam int QW             = 16;
    localparam int OW             = 15;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int ANG_UNIT_BITS  = 20;
    localparam int CORDIC_STEPS   = 24;
    localparam int CIDX_W         = 5;
    localparam int B_SHIFT        = 2;

    localparam int PROD_W = 2 * QW;
    localparam int SUM_W  = PROD_W + 2;
    localparam int B_W    = SUM_W - B_SHIFT;
    localparam int MAG_W  = B_W - 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SSQ_W  = SQ_W + 1;
    localparam int RAD_W  = SSQ_W + 1;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 4;

    localparam int CX_W    = ROOT_W + 3;
    localparam int CZ_W    = 29;
    localparam int THETA_W = 28;
    localparam int PRD_W   = MAG_W + THETA_W;
    localparam int NUM_W   = PRD_W + 1;
    localparam int Q_W     = 14;
    localparam int DEN_SH  = ANG_UNIT_BITS - ANGLE_FRAC_BITS;

    localparam int NEAR_ZERO_RATIO = 10000;
    localparam int NZ_W            = 14;
    localparam int ZMAX            = 90 << ANG_UNIT_BITS;
    localparam int RAW_LIM         = 180 << ANGLE_FRAC_BITS;
    localparam int OUT_LIM         = (RAW_LIM > 16383) ? 16383 : RAW_LIM;

    localparam logic signed [OW-1:0] ERR_MAX = OW'(OUT_LIM);
    localparam logic signed [OW-1:0] ERR_MIN = -ERR_MAX;

    typedef struct packed {
        logic [2:0]       sgn;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic [MAG_W-1:0] mag_z;
        logic [MAG_W-1:0] bw;
    } vec_side_t;

    typedef struct packed {
        logic [2:0]        sgn;
        logic [MAG_W-1:0]  mag_x;
        logic [MAG_W-1:0]  mag_y;
        logic [MAG_W-1:0]  mag_z;
        logic [ROOT_W-1:0] s;
        logic              degen;
    } ang_side_t;

    typedef struct packed {
        logic [2:0] sgn;
        logic       degen;
    } res_side_t;

    // atan(2^-i) in units of 2^-20 degree
    function automatic logic signed [CZ_W-1:0] atan_deg(input logic [CIDX_W-1:0] i);
        logic signed [CZ_W-1:0] r;
        begin
            case (i)
                5'd0:    r = CZ_W'(47185920);
                5'd1:    r = CZ_W'(27855475);
                5'd2:    r = CZ_W'(14718068);
                5'd3:    r = CZ_W'(7471121);
                5'd4:    r = CZ_W'(3750058);
                5'd5:    r = CZ_W'(1876857);
                5'd6:    r = CZ_W'(938658);
                5'd7:    r = CZ_W'(469357);
                5'd8:    r = CZ_W'(234682);
                5'd9:    r = CZ_W'(117342);
                5'd10:   r = CZ_W'(58671);
                5'd11:   r = CZ_W'(29335);
                5'd12:   r = CZ_W'(14668);
                5'd13:   r = CZ_W'(7334);
                5'd14:   r = CZ_W'(3667);
                5'd15:   r = CZ_W'(1833);
                5'd16:   r = CZ_W'(917);
                5'd17:   r = CZ_W'(458);
                5'd18:   r = CZ_W'(229);
                5'd19:   r = CZ_W'(115);
                5'd20:   r = CZ_W'(57);
                5'd21:   r = CZ_W'(29);
                5'd22:   r = CZ_W'(14);
                5'd23:   r = CZ_W'(7);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // right shift rounding toward zero
    function automatic logic signed [CX_W-1:0] shr_trunc(input logic signed [CX_W-1:0] v,
                                                         input logic [CIDX_W-1:0] sh);
        logic signed [CX_W-1:0] a;
        begin
            a = v[CX_W-1] ? -v : v;
            a = a >>> sh;
            return v[CX_W-1] ? -a : a;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/quaternion_attitude_error_core.sv
// Quaternion attitude error core: body-frame rotation vector from two attitudes.
// Depends on qae_pkg, qae_isqrt, qae_div and assert_macros.svh.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   quat    | quat_valid/quat_ready | cur_qw..cur_qz, tgt_qw..tgt_qz (16b each)
//   err     | err_valid/err_ready   | err_x, err_y, err_z (15b each)
//
// One request accepted per cycle while quat_ready is high; its result reaches the output
// register through 80 register stages: 5 ahead of the 32-stage square root, then the
// 25-stage CORDIC, 3 scaling stages, the 14-stage divider and the output register.
// Reset clears only the valid bits of the pipeline, output register and skid stage.
// A stalled output parks one result in the skid stage; quat_ready drops while it
// is occupied and the whole pipeline holds.
`default_nettype none
`include "assert_macros.svh"

module quaternion_attitude_error_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          quat_valid,
    output logic                          quat_ready,
    input  logic signed [qae_pkg::QW-1:0] cur_qw,
    input  logic signed [qae_pkg::QW-1:0] cur_qx,
    input  logic signed [qae_pkg::QW-1:0] cur_qy,
    input  logic signed [qae_pkg::QW-1:0] cur_qz,
    input  logic signed [qae_pkg::QW-1:0] tgt_qw,
    input  logic signed [qae_pkg::QW-1:0] tgt_qx,
    input  logic signed [qae_pkg::QW-1:0] tgt_qy,
    input  logic signed [qae_pkg::QW-1:0] tgt_qz,
    output logic                          err_valid,
    input  logic                          err_ready,
    output logic signed [qae_pkg::OW-1:0] err_x,
    output logic signed [qae_pkg::OW-1:0] err_y,
    output logic signed [qae_pkg::OW-1:0] err_z
);

    logic en;
    logic push;
    logic taken;
    logic out_stall;
    logic err_in_range;

    logic signed [qae_pkg::QW-1:0]     cq [0:3];
    logic signed [qae_pkg::QW-1:0]     tq [0:3];
    logic signed [qae_pkg::PROD_W-1:0] prod_reg [0:3][0:3];
    logic                              v1_reg;
    logic signed [qae_pkg::SUM_W-1:0]  sum_reg [0:3];
    logic                              v2_reg;
    logic signed [qae_pkg::SUM_W-1:0]  tr [0:3];
    logic signed [qae_pkg::B_W-1:0]    b_reg [0:3];
    logic                              v3_reg;
    logic [qae_pkg::SQ_W-1:0]          sq_reg [0:3];
    qae_pkg::vec_side_t                side4_next;
    qae_pkg::vec_side_t                side4_reg;
    logic                              v4_reg;
    logic [qae_pkg::SSQ_W-1:0]         sv_reg;
    logic [qae_pkg::SSQ_W-1:0]         nv_reg;
    qae_pkg::vec_side_t                side5_reg;
    logic                              v5_reg;

    logic [qae_pkg::ROOT_W-1:0]        s_root;
    logic [qae_pkg::ROOT_W-1:0]        n_root;
    qae_pkg::vec_side_t                sqd_reg [0:qae_pkg::ROOT_W-1];
    logic                              sqv_reg [0:qae_pkg::ROOT_W-1];
    logic [qae_pkg::ROOT_W+qae_pkg::NZ_W-1:0] s_scaled;
    qae_pkg::ang_side_t                c0_side;

    logic signed [qae_pkg::CX_W-1:0]   cx_reg [0:qae_pkg::CORDIC_STEPS];
    logic signed [qae_pkg::CX_W-1:0]   cy_reg [0:qae_pkg::CORDIC_STEPS];
    logic signed [qae_pkg::CZ_W-1:0]   cz_reg [0:qae_pkg::CORDIC_STEPS];
    qae_pkg::ang_side_t                cs_reg [0:qae_pkg::CORDIC_STEPS];
    logic                              cv_reg [0:qae_pkg::CORDIC_STEPS];

    logic signed [qae_pkg::CZ_W-1:0]   zc;
    logic [qae_pkg::THETA_W-1:0]       theta_reg;
    qae_pkg::ang_side_t                side7_reg;
    logic                              v7_reg;
    logic [qae_pkg::PRD_W-1:0]         pm_reg [0:2];
    qae_pkg::ang_side_t                side8_reg;
    logic                              v8_reg;
    logic [qae_pkg::NUM_W-1:0]         num_reg [0:2];
    logic [qae_pkg::ROOT_W-1:0]        s9_reg;
    qae_pkg::res_side_t                side9_reg;
    logic                              v9_reg;

    logic [qae_pkg::Q_W-1:0]           qt [0:2];
    qae_pkg::res_side_t                dside_reg [0:qae_pkg::Q_W-1];
    logic                              dv_reg [0:qae_pkg::Q_W-1];
    logic signed [qae_pkg::OW-1:0]     res [0:2];

    logic                              err_valid_reg;
    logic signed [qae_pkg::OW-1:0]     err_reg [0:2];
    logic                              skid_valid_reg;
    logic signed [qae_pkg::OW-1:0]     skid_reg [0:2];

    assign en         = !skid_valid_reg;
    assign quat_ready = en;
    assign taken      = err_valid_reg && err_ready;
    assign push       = en && dv_reg[qae_pkg::Q_W-1];

    assign cq[0] = cur_qw;
    assign cq[1] = cur_qx;
    assign cq[2] = cur_qy;
    assign cq[3] = cur_qz;
    assign tq[0] = tgt_qw;
    assign tq[1] = tgt_qx;
    assign tq[2] = tgt_qy;
    assign tq[3] = tgt_qz;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= quat_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v7_reg <= cv_reg[qae_pkg::CORDIC_STEPS];
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // error quaternion conj(cur) * tgt
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (sum_reg[i][qae_pkg::SUM_W-1])
                tr[i] = -((-sum_reg[i]) >>> qae_pkg::B_SHIFT);
            else
                tr[i] = sum_reg[i] >>> qae_pkg::B_SHIFT;
        end
    end

    always_comb
    begin
        side4_next.sgn   = {b_reg[1][qae_pkg::B_W-1], b_reg[2][qae_pkg::B_W-1],
                            b_reg[3][qae_pkg::B_W-1]};
        side4_next.mag_x = qae_pkg::MAG_W'(b_reg[1][qae_pkg::B_W-1] ? -b_reg[1] : b_reg[1]);
        side4_next.mag_y = qae_pkg::MAG_W'(b_reg[2][qae_pkg::B_W-1] ? -b_reg[2] : b_reg[2]);
        side4_next.mag_z = qae_pkg::MAG_W'(b_reg[3][qae_pkg::B_W-1] ? -b_reg[3] : b_reg[3]);
        side4_next.bw    = qae_pkg::MAG_W'(b_reg[0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int t = 0; t < 4; t++)
                begin
                    prod_reg[c][t] <= qae_pkg::PROD_W'(cq[c] * tq[t]);
                end
            end
            sum_reg[0] <= qae_pkg::SUM_W'(prod_reg[0][0]) + qae_pkg::SUM_W'(prod_reg[1][1])
                        + qae_pkg::SUM_W'(prod_reg[2][2]) + qae_pkg::SUM_W'(prod_reg[3][3]);
            sum_reg[1] <= qae_pkg::SUM_W'(prod_reg[0][1]) - qae_pkg::SUM_W'(prod_reg[1][0])
                        - qae_pkg::SUM_W'(prod_reg[2][3]) + qae_pkg::SUM_W'(prod_reg[3][2]);
            sum_reg[2] <= qae_pkg::SUM_W'(prod_reg[0][2]) + qae_pkg::SUM_W'(prod_reg[1][3])
                        - qae_pkg::SUM_W'(prod_reg[2][0]) - qae_pkg::SUM_W'(prod_reg[3][1]);
            sum_reg[3] <= qae_pkg::SUM_W'(prod_reg[0][3]) - qae_pkg::SUM_W'(prod_reg[1][2])
                        + qae_pkg::SUM_W'(prod_reg[2][1]) - qae_pkg::SUM_W'(prod_reg[3][0]);
            for (int i = 0; i < 4; i++)
            begin
                b_reg[i] <= qae_pkg::B_W'(tr[0][qae_pkg::SUM_W-1] ? -tr[i] : tr[i]);
                sq_reg[i] <= qae_pkg::SQ_W'(b_reg[i] * b_reg[i]);
            end
            side4_reg <= side4_next;
            sv_reg    <= qae_pkg::SSQ_W'(sq_reg[1]) + qae_pkg::SSQ_W'(sq_reg[2])
                       + qae_pkg::SSQ_W'(sq_reg[3]);
            nv_reg    <= (qae_pkg::SSQ_W'(sq_reg[1]) + qae_pkg::SSQ_W'(sq_reg[2]))
                       + (qae_pkg::SSQ_W'(sq_reg[3]) + qae_pkg::SSQ_W'(sq_reg[0]));
            side5_reg <= side4_reg;
        end
    end

    // vector-part length and full length
    qae_isqrt u_sqrt_s (
        .clk      (clk),
        .en       (en),
        .radicand ({1'b0, sv_reg}),
        .root     (s_root)
    );

    qae_isqrt u_sqrt_n (
        .clk      (clk),
        .en       (en),
        .radicand ({1'b0, nv_reg}),
        .root     (n_root)
    );

    genvar k;
    generate
        for (k = 0; k < qae_pkg::ROOT_W; k++)
        begin : g_sqd
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sqv_reg[k] <= 1'b0;
                else if (en)
                    sqv_reg[k] <= (k == 0) ? v5_reg : sqv_reg[(k == 0) ? 0 : k-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    sqd_reg[k] <= (k == 0) ? side5_reg : sqd_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    assign s_scaled = (qae_pkg::ROOT_W+qae_pkg::NZ_W)'(s_root)
                    * (qae_pkg::ROOT_W+qae_pkg::NZ_W)'(qae_pkg::NEAR_ZERO_RATIO);

    always_comb
    begin
        c0_side.sgn   = sqd_reg[qae_pkg::ROOT_W-1].sgn;
        c0_side.mag_x = sqd_reg[qae_pkg::ROOT_W-1].mag_x;
        c0_side.mag_y = sqd_reg[qae_pkg::ROOT_W-1].mag_y;
        c0_side.mag_z = sqd_reg[qae_pkg::ROOT_W-1].mag_z;
        c0_side.s     = s_root;
        c0_side.degen = (s_root == '0)
                     || (s_scaled < (qae_pkg::ROOT_W+qae_pkg::NZ_W)'(n_root));
    end

    // CORDIC vectoring on (bw, s)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (en)
            cv_reg[0] <= sqv_reg[qae_pkg::ROOT_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= qae_pkg::CX_W'(sqd_reg[qae_pkg::ROOT_W-1].bw);
            cy_reg[0] <= qae_pkg::CX_W'(s_root);
            cz_reg[0] <= '0;
            cs_reg[0] <= c0_side;
        end
    end

    generate
        for (k = 0; k < qae_pkg::CORDIC_STEPS; k++)
        begin : g_cordic
            logic signed [qae_pkg::CX_W-1:0] dx;
            logic signed [qae_pkg::CX_W-1:0] dy;
            logic signed [qae_pkg::CZ_W-1:0] da;

            assign dx = qae_pkg::shr_trunc(cx_reg[k], qae_pkg::CIDX_W'(k));
            assign dy = qae_pkg::shr_trunc(cy_reg[k], qae_pkg::CIDX_W'(k));
            assign da = qae_pkg::atan_deg(qae_pkg::CIDX_W'(k));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    cv_reg[k+1] <= 1'b0;
                else if (en)
                    cv_reg[k+1] <= cv_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (cy_reg[k] > 0)
                    begin
                        cx_reg[k+1] <= cx_reg[k] + dy;
                        cy_reg[k+1] <= cy_reg[k] - dx;
                        cz_reg[k+1] <= cz_reg[k] + da;
                    end
                    else
                    begin
                        cx_reg[k+1] <= cx_reg[k] - dy;
                        cy_reg[k+1] <= cy_reg[k] + dx;
                        cz_reg[k+1] <= cz_reg[k] - da;
                    end
                    cs_reg[k+1] <= cs_reg[k];
                end
            end
        end
    endgenerate

    // clamp angle, scale components
    always_comb
    begin
        if (cz_reg[qae_pkg::CORDIC_STEPS] < 0)
            zc = '0;
        else if (cz_reg[qae_pkg::CORDIC_STEPS] > qae_pkg::CZ_W'(qae_pkg::ZMAX))
            zc = qae_pkg::CZ_W'(qae_pkg::ZMAX);
        else
            zc = cz_reg[qae_pkg::CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg <= {zc[qae_pkg::THETA_W-2:0], 1'b0};
            side7_reg <= cs_reg[qae_pkg::CORDIC_STEPS];
            pm_reg[0] <= qae_pkg::PRD_W'(side7_reg.mag_x) * qae_pkg::PRD_W'(theta_reg);
            pm_reg[1] <= qae_pkg::PRD_W'(side7_reg.mag_y) * qae_pkg::PRD_W'(theta_reg);
            pm_reg[2] <= qae_pkg::PRD_W'(side7_reg.mag_z) * qae_pkg::PRD_W'(theta_reg);
            side8_reg <= side7_reg;
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= qae_pkg::NUM_W'(pm_reg[i])
                            + (qae_pkg::NUM_W'(side8_reg.s) << (qae_pkg::DEN_SH - 1));
            end
            s9_reg          <= side8_reg.s;
            side9_reg.sgn   <= side8_reg.sgn;
            side9_reg.degen <= side8_reg.degen;
        end
    end

    generate
        for (k = 0; k < 3; k++)
        begin : g_div
            qae_div u_div (
                .clk  (clk),
                .en   (en),
                .num  (num_reg[k]),
                .s    (s9_reg),
                .quot (qt[k])
            );
        end

        for (k = 0; k < qae_pkg::Q_W; k++)
        begin : g_dd
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_reg[k] <= 1'b0;
                else if (en)
                    dv_reg[k] <= (k == 0) ? v9_reg : dv_reg[(k == 0) ? 0 : k-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    dside_reg[k] <= (k == 0) ? side9_reg : dside_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    // saturate, apply sign, zero degenerate rotations
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dside_reg[qae_pkg::Q_W-1].degen)
                res[i] = '0;
            else
            begin
                res[i] = (qae_pkg::OW'(qt[i]) > qae_pkg::ERR_MAX) ? qae_pkg::ERR_MAX
                                                                  : qae_pkg::OW'(qt[i]);
                if (dside_reg[qae_pkg::Q_W-1].sgn[2-i])
                    res[i] = -res[i];
            end
        end
    end

    // output register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (taken)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!err_valid_reg || taken)
                err_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (taken)
        begin
            err_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (skid_valid_reg)
            begin
                if (taken)
                    err_reg[i] <= skid_reg[i];
            end
            else if (push)
            begin
                if (!err_valid_reg || taken)
                    err_reg[i] <= res[i];
                else
                    skid_reg[i] <= res[i];
            end
        end
    end

    assign err_valid = err_valid_reg;
    assign err_x     = err_reg[0];
    assign err_y     = err_reg[1];
    assign err_z     = err_reg[2];

    assign out_stall    = push && err_valid_reg && !err_ready;
    assign err_in_range = (err_x <= qae_pkg::ERR_MAX) && (err_x >= qae_pkg::ERR_MIN)
                       && (err_y <= qae_pkg::ERR_MAX) && (err_y >= qae_pkg::ERR_MIN)
                       && (err_z <= qae_pkg::ERR_MAX) && (err_z >= qae_pkg::ERR_MIN);

    `QAE_ASSERT(a_skid_needs_out, skid_valid_reg |-> err_valid_reg, "skid full with output empty")
    `QAE_ASSERT_NEXT(a_skid_fill, out_stall, skid_valid_reg, "stalled result dropped")
    `QAE_ASSERT(a_err_range, err_valid_reg |-> err_in_range, "error out of range")

endmodule

`default_nettype wire

FILE: hw/rtl/qae_isqrt.sv
// Pipelined integer square root, one result bit per stage (floor).
// Depends on qae_pkg.
`default_nettype none

module qae_isqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [qae_pkg::RAD_W-1:0]   radicand,
    output logic [qae_pkg::ROOT_W-1:0]  root
);

    logic [qae_pkg::REM_W-1:0]  rem_d    [0:qae_pkg::ROOT_W-1];
    logic [qae_pkg::REM_W-1:0]  rem_reg  [0:qae_pkg::ROOT_W-1];
    logic [qae_pkg::ROOT_W-1:0] root_d   [0:qae_pkg::ROOT_W-1];
    logic [qae_pkg::ROOT_W-1:0] root_reg [0:qae_pkg::ROOT_W-1];
    logic [qae_pkg::RAD_W-1:0]  rad_d    [0:qae_pkg::ROOT_W-1];
    logic [qae_pkg::RAD_W-1:0]  rad_reg  [0:qae_pkg::ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < qae_pkg::ROOT_W; k++)
        begin : g_stage
            logic [qae_pkg::REM_W-1:0] cur;
            logic [qae_pkg::REM_W-1:0] trial;
            logic                      ge;

            if (k == 0)
            begin : g_first
                assign rem_d[k]  = '0;
                assign root_d[k] = '0;
                assign rad_d[k]  = radicand;
            end
            else
            begin : g_next
                assign rem_d[k]  = rem_reg[k-1];
                assign root_d[k] = root_reg[k-1];
                assign rad_d[k]  = rad_reg[k-1];
            end

            assign cur   = {rem_d[k][qae_pkg::REM_W-3:0], rad_d[k][qae_pkg::RAD_W-1 -: 2]};
            assign trial = {2'b00, root_d[k], 2'b01};
            assign ge    = (cur >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? (cur - trial) : cur;
                    root_reg[k] <= {root_d[k][qae_pkg::ROOT_W-2:0], ge};
                    rad_reg[k]  <= {rad_d[k][qae_pkg::RAD_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[qae_pkg::ROOT_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/qae_div.sv
// Pipelined restoring divider: quotient of num by (s << DEN_SH), one bit per stage.
// Depends on qae_pkg.
`default_nettype none

module qae_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [qae_pkg::NUM_W-1:0]   num,
    input  logic [qae_pkg::ROOT_W-1:0]  s,
    output logic [qae_pkg::Q_W-1:0]     quot
);

    logic [qae_pkg::NUM_W-1:0] rem_d   [0:qae_pkg::Q_W-1];
    logic [qae_pkg::NUM_W-1:0] rem_reg [0:qae_pkg::Q_W-1];
    logic [qae_pkg::NUM_W-1:0] den_d   [0:qae_pkg::Q_W-1];
    logic [qae_pkg::NUM_W-1:0] den_reg [0:qae_pkg::Q_W-1];
    logic [qae_pkg::Q_W-1:0]   q_d     [0:qae_pkg::Q_W-1];
    logic [qae_pkg::Q_W-1:0]   q_reg   [0:qae_pkg::Q_W-1];

    genvar k;
    generate
        for (k = 0; k < qae_pkg::Q_W; k++)
        begin : g_stage
            logic [qae_pkg::NUM_W-1:0] dsh;
            logic                      ge;

            if (k == 0)
            begin : g_first
                assign rem_d[k] = num;
                assign den_d[k] = qae_pkg::NUM_W'(s) << qae_pkg::DEN_SH;
                assign q_d[k]   = '0;
            end
            else
            begin : g_next
                assign rem_d[k] = rem_reg[k-1];
                assign den_d[k] = den_reg[k-1];
                assign q_d[k]   = q_reg[k-1];
            end

            assign dsh = den_d[k] << (qae_pkg::Q_W - 1 - k);
            assign ge  = (rem_d[k] >= dsh);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (rem_d[k] - dsh) : rem_d[k];
                    den_reg[k] <= den_d[k];
                    q_reg[k]   <= {q_d[k][qae_pkg::Q_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign quot = q_reg[qae_pkg::Q_W-1];

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for quaternion_attitude_error_core: directed table, then
// unit-quaternion pairs, near pairs and raw noise, most under random handshake idling.
// Depends on qae_pkg and the core RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_ITEMS = 1250;

    typedef logic signed [qae_pkg::QW-1:0] quat_word_t;

    typedef struct packed {
        logic signed [qae_pkg::OW-1:0] x;
        logic signed [qae_pkg::OW-1:0] y;
        logic signed [qae_pkg::OW-1:0] z;
    } err_vec_t;

    typedef struct {
        quat_word_t q[8];
        bit         has_exp;
        err_vec_t   exp_err;
    } stim_row_t;

    localparam longint ATAN_DEG[qae_pkg::CORDIC_STEPS] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14, 7
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic quat_valid = 1'b0;
    logic quat_ready;
    quat_word_t cur_qw = '0, cur_qx = '0, cur_qy = '0, cur_qz = '0;
    quat_word_t tgt_qw = '0, tgt_qx = '0, tgt_qy = '0, tgt_qz = '0;
    logic err_valid;
    logic err_ready = 1'b0;
    logic signed [qae_pkg::OW-1:0] err_x, err_y, err_z;

    err_vec_t   pending_err[$];
    stim_row_t  stim_table[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    always #1 clk = ~clk;

    quaternion_attitude_error_core uut (
        .clk(clk), .rst_n(rst_n),
        .quat_valid(quat_valid), .quat_ready(quat_ready),
        .cur_qw(cur_qw), .cur_qx(cur_qx), .cur_qy(cur_qy), .cur_qz(cur_qz),
        .tgt_qw(tgt_qw), .tgt_qx(tgt_qx), .tgt_qy(tgt_qy), .tgt_qz(tgt_qz),
        .err_valid(err_valid), .err_ready(err_ready),
        .err_x(err_x), .err_y(err_y), .err_z(err_z)
    );

    function automatic longint trunc_shift(longint v, int sh);
        return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned a);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > a)
            b >>= 2;
        while (b != 0)
        begin
            if (a >= r + b)
            begin
                a -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [qae_pkg::OW-1:0] scale_axis(longint v, longint theta,
                                                                 longint unsigned s);
        longint unsigned mag;
        longint unsigned den;
        longint q;
        mag = (v < 0) ? -v : v;
        den = s << qae_pkg::DEN_SH;
        q = (mag * theta + den / 2) / den;
        if (q > qae_pkg::OUT_LIM)
            q = qae_pkg::OUT_LIM;
        if (v < 0)
            q = -q;
        return qae_pkg::OW'(q);
    endfunction

    function automatic err_vec_t attitude_error(quat_word_t q[8]);
        longint cw, cx, cy, cz, tw, tx, ty, tz;
        longint bw, bx, by, bz, x, y, z, dx, dy;
        longint unsigned vsq, s, n;
        err_vec_t r;
        cw = q[0]; cx = q[1]; cy = q[2]; cz = q[3];
        tw = q[4]; tx = q[5]; ty = q[6]; tz = q[7];
        bw = trunc_shift(cw * tw + cx * tx + cy * ty + cz * tz, qae_pkg::B_SHIFT);
        bx = trunc_shift(cw * tx - cx * tw - cy * tz + cz * ty, qae_pkg::B_SHIFT);
        by = trunc_shift(cw * ty + cx * tz - cy * tw - cz * tx, qae_pkg::B_SHIFT);
        bz = trunc_shift(cw * tz - cx * ty + cy * tx - cz * tw, qae_pkg::B_SHIFT);
        if (bw < 0)
        begin
            bw = -bw; bx = -bx; by = -by; bz = -bz;
        end
        vsq = bx * bx + by * by + bz * bz;
        s = int_sqrt(vsq);
        n = int_sqrt(vsq + bw * bw);
        r = '0;
        if (s == 0 || s * qae_pkg::NEAR_ZERO_RATIO < n)
            return r;
        x = bw;
        y = s;
        z = 0;
        for (int i = 0; i < qae_pkg::CORDIC_STEPS; i++)
        begin
            dx = trunc_shift(x, i);
            dy = trunc_shift(y, i);
            if (y > 0)
            begin
                x += dy; y -= dx; z += ATAN_DEG[i];
            end
            else
            begin
                x -= dy; y += dx; z -= ATAN_DEG[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > qae_pkg::ZMAX)
            z = qae_pkg::ZMAX;
        r.x = scale_axis(bx, 2 * z, s);
        r.y = scale_axis(by, 2 * z, s);
        r.z = scale_axis(bz, 2 * z, s);
        return r;
    endfunction

    task automatic add_row(input int a0, a1, a2, a3, a4, a5, a6, a7, input bit zero_exp);
        stim_row_t row;
        row.q = '{quat_word_t'(a0), quat_word_t'(a1), quat_word_t'(a2), quat_word_t'(a3),
                  quat_word_t'(a4), quat_word_t'(a5), quat_word_t'(a6), quat_word_t'(a7)};
        row.has_exp = zero_exp;
        row.exp_err = '0;
        stim_table.push_back(row);
    endtask

    function automatic void unit_quat(output quat_word_t u[4]);
        real c[4];
        real len;
        do
        begin
            len = 0.0;
            for (int i = 0; i < 4; i++)
            begin
                c[i] = ($itor($urandom_range(65535)) - 32768.0) / 32768.0;
                len += c[i] * c[i];
            end
        end while (len < 1.0e-3);
        len = $sqrt(len);
        for (int i = 0; i < 4; i++)
            u[i] = quat_word_t'($rtoi(c[i] / len * 16384.0 + (c[i] < 0 ? -0.5 : 0.5)));
    endfunction

    function automatic void random_item(output quat_word_t q[8]);
        quat_word_t u[4];
        quat_word_t v[4];
        int kind;
        int spread;
        kind = $urandom_range(99);
        unit_quat(u);
        if (kind < 15)
        begin
            for (int i = 0; i < 8; i++)
                q[i] = quat_word_t'($urandom);
            return;
        end
        if (kind < 45)
        begin
            spread = 1 << $urandom_range(10);
            for (int i = 0; i < 4; i++)
                v[i] = u[i] + quat_word_t'($urandom_range(2 * spread) - spread);
        end
        else
            unit_quat(v);
        if ($urandom_range(3) == 0)
            for (int i = 0; i < 4; i++)
                v[i] = -v[i];
        for (int i = 0; i < 4; i++)
        begin
            q[i] = u[i];
            q[i + 4] = v[i];
        end
    endfunction

    task automatic send_request(input quat_word_t q[8], input bit has_exp,
                                input err_vec_t exp_err);
        while ($urandom_range(99) < send_idle_pct)
        begin
            quat_valid <= 1'b0;
            @(posedge clk);
        end
        quat_valid <= 1'b1;
        cur_qw <= q[0]; cur_qx <= q[1]; cur_qy <= q[2]; cur_qz <= q[3];
        tgt_qw <= q[4]; tgt_qx <= q[5]; tgt_qy <= q[6]; tgt_qz <= q[7];
        @(posedge clk);
        while (!quat_ready)
            @(posedge clk);
        pending_err.push_back(has_exp ? exp_err : attitude_error(q));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && err_valid && err_ready)
        begin
            if (pending_err.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d", err_x, err_y, err_z);
            end
            else
            begin
                err_vec_t e;
                e = pending_err.pop_front();
                if (e.x !== err_x || e.y !== err_y || e.z !== err_z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 e.x, e.y, e.z, err_x, err_y, err_z);
                end
            end
        end
        err_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((quat_valid && quat_ready) || (err_valid && err_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        quat_word_t q[8];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(16384, 0, 0, 0, 16384, 0, 0, 0, 1);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1);
        add_row(16384, 0, 0, 0, -16384, 0, 0, 0, 1);
        add_row(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 1);
        add_row(16384, 0, 0, 0, 16383, 1, 0, 0, 1);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1);
        add_row(16384, 0, 0, 0, 0, 16384, 0, 0, 0);
        add_row(16384, 0, 0, 0, 0, 0, 16384, 0, 0);
        add_row(16384, 0, 0, 0, 0, 0, 0, 16384, 0);
        add_row(16384, 0, 0, 0, 0, -16384, 0, 0, 0);
        add_row(16384, 0, 0, 0, 0, -11585, 0, 11585, 0);
        add_row(16384, 0, 0, 0, 11585, 0, 0, 11585, 0);
        add_row(11585, 11585, 0, 0, 11585, 0, 11585, 0, 0);
        add_row(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 0);
        add_row(32767, 0, 0, 0, -32768, 0, 0, 0, 0);
        add_row(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 0);
        add_row(16384, 0, 0, 0, 16380, 2, -2, 2, 0);
        add_row(16384, 0, 0, 0, 16300, 1200, -900, 600, 0);
        add_row(-16384, 0, 0, 0, 0, 0, 0, -16384, 0);

        foreach (stim_table[i])
            send_request(stim_table[i].q, stim_table[i].has_exp, stim_table[i].exp_err);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 17 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                random_item(q);
                send_request(q, 1'b0, '0);
            end
            quat_valid <= 1'b0;
            @(posedge clk);
            while (pending_err.size() != 0)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_err.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: quaternion_attitude_error_core.f
+incdir+hw/rtl
hw/rtl/qae_pkg.sv
hw/rtl/qae_isqrt.sv
hw/rtl/qae_div.sv
hw/rtl/quaternion_attitude_error_core.sv
tb/tb_top.sv
